>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the GHASH top-level design file
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at each rising edge, disabled while reset is asserted
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) else $error(msg);

// check a property at each rising edge, reset included
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> design/ghm_pkg.sv
// ----------------------------------------------------------------------------
// ghm_pkg
// Shared constants, types and helpers for the GHASH multiply-accumulate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ghm_pkg;

  localparam int BLOCK_W         = 128;
  localparam int HALF_W          = 64;
  localparam int DIGIT_WIDTH_DEF = 32;
  localparam int APB_ADDR_W      = 4;

  // low terms of x^128 + x^7 + x^2 + x + 1, and the degree of the highest one
  localparam logic [7:0] POLY_LOW = 8'h87;
  localparam int         POLY_DEG = 7;

  // register index, taken from paddr[3]
  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_idx_t;

  // engine status towards the top level
  typedef struct packed {
    logic running;
    logic last;
    logic finishing;
    logic holding;
  } ghm_sts_t;

  // reverse the bit order inside every byte
  function automatic logic [BLOCK_W-1:0] rev_bytes_bits(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int b = 0; b < BLOCK_W / 8; b++) begin
      for (int i = 0; i < 8; i++) begin
        r[b*8 + i] = v[b*8 + 7 - i];
      end
    end
    return r;
  endfunction

endpackage

>>> design/ghm_digit_step.sv
// ----------------------------------------------------------------------------
// ghm_digit_step
// One digit pass: z * x^DW + a * digit, reduced modulo the GCM polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghm_digit_step #(
  parameter int DIGIT_WIDTH = ghm_pkg::DIGIT_WIDTH_DEF
) (
  input  logic [ghm_pkg::BLOCK_W-1:0] z_i,
  input  logic [ghm_pkg::BLOCK_W-1:0] a_i,
  input  logic [DIGIT_WIDTH-1:0]      digit_i,
  output logic [ghm_pkg::BLOCK_W-1:0] z_o
);

  localparam int BW     = ghm_pkg::BLOCK_W;
  localparam int WIDE_W = BW + DIGIT_WIDTH;
  localparam int FOLD_W = BW + ghm_pkg::POLY_DEG + 1;
  localparam int OV_W   = ghm_pkg::POLY_DEG + 1;
  localparam int G_W    = 2 * OV_W;

  logic [WIDE_W-1:0]      wide;
  logic [DIGIT_WIDTH-1:0] hi;
  logic [FOLD_W-1:0]      fold;
  logic [OV_W-1:0]        ov;
  logic [G_W-1:0]         fold2;

  always_comb begin
    // shift the running sum up by one digit and add the partial products
    wide = {z_i, {DIGIT_WIDTH{1'b0}}};
    for (int j = 0; j < DIGIT_WIDTH; j++) begin
      if (digit_i[j]) begin
        wide = wide ^ (WIDE_W'(a_i) << j);
      end
    end

    // fold the bits above x^127 back through the polynomial
    hi   = wide[WIDE_W-1:BW];
    fold = '0;
    for (int i = 0; i < DIGIT_WIDTH; i++) begin
      if (hi[i]) begin
        fold = fold ^ (FOLD_W'(ghm_pkg::POLY_LOW) << i);
      end
    end

    // a second, short fold for the few bits that the first one pushes over
    ov    = fold[FOLD_W-1:BW];
    fold2 = '0;
    for (int i = 0; i < OV_W; i++) begin
      if (ov[i]) begin
        fold2 = fold2 ^ (G_W'(ghm_pkg::POLY_LOW) << i);
      end
    end

    z_o = wide[BW-1:0] ^ fold[BW-1:0] ^ BW'(fold2);
  end

endmodule

>>> design/ghm_apb_regs.sv
// ----------------------------------------------------------------------------
// ghm_apb_regs
// APB register file holding the two 64-bit halves of the hash key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghm_apb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ghm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ghm_pkg::HALF_W-1:0]     pwdata,
  output logic [ghm_pkg::HALF_W-1:0]     prdata,
  output logic                           pready,
  output logic [ghm_pkg::BLOCK_W-1:0]    key_raw
);

  logic [ghm_pkg::HALF_W-1:0] key_low_r;
  logic [ghm_pkg::HALF_W-1:0] key_high_r;
  logic                       wr_en;
  ghm_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = ghm_pkg::reg_idx_t'(paddr[3]);

  // write the addressed key half in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (wr_en) begin
      case (idx)
        ghm_pkg::REG_KEY_LOW:  key_low_r  <= pwdata;
        ghm_pkg::REG_KEY_HIGH: key_high_r <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      ghm_pkg::REG_KEY_LOW:  prdata = key_low_r;
      ghm_pkg::REG_KEY_HIGH: prdata = key_high_r;
      default:               prdata = '0;
    endcase
  end

  assign key_raw = {key_high_r, key_low_r};

endmodule

>>> design/ghm_engine.sv
// ----------------------------------------------------------------------------
// ghm_engine
// Sequencer, accumulator and output register around the shared digit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ghm_engine #(
  parameter int DIGIT_WIDTH = ghm_pkg::DIGIT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ghm_pkg::BLOCK_W-1:0] in_block,
  input  logic [ghm_pkg::BLOCK_W-1:0] key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ghm_pkg::BLOCK_W-1:0] out_digest,
  output ghm_pkg::ghm_sts_t           sts
);

  localparam int BW     = ghm_pkg::BLOCK_W;
  localparam int DIGITS = (BW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int EXT_W  = DIGITS * DIGIT_WIDTH;
  localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DIGITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [BW-1:0]          acc_r, acc_nxt;
  logic [BW-1:0]          a_r, a_nxt;
  logic [BW-1:0]          digest_r, digest_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [EXT_W-1:0]       key_ext;
  logic [DIGIT_WIDTH-1:0] key_digit;
  logic [BW-1:0]          step_z;
  logic                   last;
  logic                   finishing;
  logic                   out_free;
  logic                   accept;
  logic [BW-1:0]          acc_base;
  logic [BW-1:0]          a_load;

  // pick the key digit for this pass, most significant first
  assign key_ext   = EXT_W'(key);
  assign key_digit = key_ext[cnt_r*DIGIT_WIDTH +: DIGIT_WIDTH];

  ghm_digit_step #(
    .DIGIT_WIDTH (DIGIT_WIDTH)
  ) u_step (
    .z_i     (acc_r),
    .a_i     (a_r),
    .digit_i (key_digit),
    .z_o     (step_z)
  );

  // handshake decode: a new block may enter when idle, or on the last pass with room at the output
  assign last      = (cnt_r == '0);
  assign finishing = (state_r == ST_RUN) && last;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) || (finishing && out_free);
  assign accept    = in_valid && in_ready;

  // operand for the next multiply: accumulator (or zero on restart) plus block
  assign acc_base = (state_r == ST_IDLE) ? acc_r : step_z;
  assign a_load   = (in_action ? '0 : acc_base) ^ ghm_pkg::rev_bytes_bits(in_block);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_nxt     = a_load;
          acc_nxt   = '0;
          cnt_nxt   = CNT_TOP;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        acc_nxt = step_z;
        if (!last) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (out_free) begin
          digest_nxt    = ghm_pkg::rev_bytes_bits(step_z);
          out_valid_nxt = 1'b1;
          if (accept) begin
            a_nxt   = a_load;
            acc_nxt = '0;
            cnt_nxt = CNT_TOP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (out_free) begin
          digest_nxt    = ghm_pkg::rev_bytes_bits(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand and result payload
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    digest_r <= digest_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_digest = digest_r;

  assign sts.running   = (state_r == ST_RUN);
  assign sts.last      = last;
  assign sts.finishing = finishing;
  assign sts.holding   = (state_r == ST_HOLD);

endmodule

>>> design/ghash_multiply_accumulate.sv
// Operation: the key is split into DIGITS = ceil(128 / DIGIT_WIDTH) digits (4 at DIGIT_WIDTH = 32),
//   taken most significant first, one per pass of the shared digit unit; the last pass loads
//   the digest register, or the result waits in a hold state while the output is occupied.
// A new block may enter on the last digit pass while results are taken, else from idle.
// Reset (synchronous, rst_n low): accumulator and both key halves cleared, no result held.
// ----------------------------------------------------------------------------
// ghash_multiply_accumulate
// GHASH multiply-accumulate over GF(2^128) with an APB key register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ghash_multiply_accumulate #(
  parameter int DIGIT_WIDTH = ghm_pkg::DIGIT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ghm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ghm_pkg::HALF_W-1:0]     pwdata,
  output logic [ghm_pkg::HALF_W-1:0]     prdata,
  output logic                           pready,
  // data blocks
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [ghm_pkg::HALF_W-1:0]     in_block_low,
  input  logic [ghm_pkg::HALF_W-1:0]     in_block_high,
  // digests
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ghm_pkg::HALF_W-1:0]     out_digest_low,
  output logic [ghm_pkg::HALF_W-1:0]     out_digest_high
);

  logic [ghm_pkg::BLOCK_W-1:0] key_raw;
  logic [ghm_pkg::BLOCK_W-1:0] key_rev;
  logic [ghm_pkg::BLOCK_W-1:0] digest;
  ghm_pkg::ghm_sts_t           sts;

  ghm_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_raw (key_raw)
  );

  // the key is used in the bit-reversed domain
  assign key_rev = ghm_pkg::rev_bytes_bits(key_raw);

  ghm_engine #(
    .DIGIT_WIDTH (DIGIT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_block   ({in_block_high, in_block_low}),
    .key        (key_rev),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_digest (digest),
    .sts        (sts)
  );

  assign out_digest_low  = digest[ghm_pkg::HALF_W-1:0];
  assign out_digest_high = digest[ghm_pkg::BLOCK_W-1:ghm_pkg::HALF_W];

  // a transaction overlaps a running multiply only on its last pass with room at the output
  `ASSERT_CLK(a_overlap_last, clk, rst_n, (in_valid && in_ready && sts.running) |-> (sts.last && (!out_valid || out_ready)), "block accepted mid-multiply")

  // a digest appears only after a finishing pass or a drained hold
  `ASSERT_CLK(a_out_source, clk, rst_n, $rose(out_valid) |-> $past(sts.finishing || sts.holding), "digest without a finished multiply")

  // a held result means the output register is occupied
  `ASSERT_CLK(a_hold_full, clk, rst_n, sts.holding |-> out_valid, "hold state with empty output")

  // reset leaves no digest pending
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "digest pending after reset")

endmodule

>>> tb/ghash_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_digest_checker
// Watches the key port and both data channels of the GHASH block, keeps its
// own copy of the key and accumulator, and compares every digest transaction
// with the oldest digest still owed.
// ----------------------------------------------------------------------------

package ghash_tb_pkg;

  // meaning of the in_action bit
  typedef enum logic {
    ABSORB  = 1'b0,
    RESTART = 1'b1
  } ghash_action_t;

endpackage

module ghash_digest_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ghm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ghm_pkg::HALF_W-1:0]     pwdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_action,
  input  logic [ghm_pkg::HALF_W-1:0]     in_block_low,
  input  logic [ghm_pkg::HALF_W-1:0]     in_block_high,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ghm_pkg::HALF_W-1:0]     out_digest_low,
  input  logic [ghm_pkg::HALF_W-1:0]     out_digest_high,
  output int                             error_count,
  output int                             digests_owed
);

  import ghm_pkg::*;
  import ghash_tb_pkg::*;

  // low terms of the field polynomial, folded back in on each overflow
  localparam logic [7:0] FIELD_TAIL = 8'h87;

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } digest_t;

  logic [HALF_W-1:0]  hash_key_low;
  logic [HALF_W-1:0]  hash_key_high;
  logic [BLOCK_W-1:0] running_hash;
  digest_t            owed_digests[$];

  initial begin
    error_count  = 0;
    digests_owed = 0;
  end

  // reverse the bit order inside every byte of a 64-bit half
  function automatic logic [HALF_W-1:0] flip_byte_bits(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] r;
    for (int i = 0; i < HALF_W; i++) begin
      r[i] = v[(i & ~7) + 7 - (i & 7)];
    end
    return r;
  endfunction

  // carry-less product reduced modulo x^128 + x^7 + x^2 + x + 1,
  // walking the key from its top coefficient down
  function automatic logic [BLOCK_W-1:0] gf128_product(input logic [BLOCK_W-1:0] a,
                                                       input logic [BLOCK_W-1:0] k);
    logic [BLOCK_W-1:0] z;
    z = '0;
    for (int pos = BLOCK_W - 1; pos >= 0; pos--) begin
      z = {z[BLOCK_W-2:0], 1'b0} ^ (z[BLOCK_W-1] ? {120'd0, FIELD_TAIL} : '0);
      if (k[pos]) begin
        z ^= a;
      end
    end
    return z;
  endfunction

  // fold one data block into the running hash and return the new hash
  function automatic logic [BLOCK_W-1:0] ghash_fold(input logic [BLOCK_W-1:0] prior,
                                                    input ghash_action_t act,
                                                    input logic [HALF_W-1:0] blk_low,
                                                    input logic [HALF_W-1:0] blk_high);
    logic [BLOCK_W-1:0] a;
    logic [BLOCK_W-1:0] k;
    a = (act == RESTART) ? '0 : prior;
    a ^= {flip_byte_bits(blk_high), flip_byte_bits(blk_low)};
    k = {flip_byte_bits(hash_key_high), flip_byte_bits(hash_key_low)};
    return gf128_product(a, k);
  endfunction

  task automatic log_fault(input string what, input digest_t want, input digest_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s: expected low %h high %h, got low %h high %h",
               $realtime, what, want.low, want.high, got.low, got.high);
    end
  endtask

  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (!rst_n) begin
      hash_key_low  = '0;
      hash_key_high = '0;
      running_hash  = '0;
      owed_digests.delete();
    end else begin
      // track key writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3]))
          REG_KEY_LOW:  hash_key_low  = pwdata;
          REG_KEY_HIGH: hash_key_high = pwdata;
          default: ;
        endcase
      end
      // retire the oldest owed digest first, so a same-edge block never pairs with it
      if (out_valid && out_ready) begin
        got.low  = out_digest_low;
        got.high = out_digest_high;
        if (owed_digests.size() == 0) begin
          log_fault("digest transaction with no block outstanding", '0, got);
        end else begin
          want = owed_digests.pop_front();
          if (got.low !== want.low || got.high !== want.high) begin
            log_fault("digest mismatch", want, got);
          end
        end
      end
      // predict the digest of each accepted block
      if (in_valid && in_ready) begin
        running_hash = ghash_fold(running_hash, ghash_action_t'(in_action),
                                  in_block_low, in_block_high);
        want.low  = flip_byte_bits(running_hash[HALF_W-1:0]);
        want.high = flip_byte_bits(running_hash[BLOCK_W-1:HALF_W]);
        owed_digests.push_back(want);
      end
    end
    digests_owed = owed_digests.size();
  end

endmodule

>>> tb/ghash_multiply_accumulate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_multiply_accumulate_tb
// Drives data blocks and key writes into the GHASH block under random idling
// on both channels, and gives the verdict from the checker's error and owed-digest counts.
// ----------------------------------------------------------------------------

module ghash_multiply_accumulate_tb;

  import ghm_pkg::*;
  import ghash_tb_pkg::*;

  localparam logic [HALF_W-1:0] ALL_ONES = '1;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [APB_ADDR_W-1:0] paddr           = '0;
  logic [HALF_W-1:0]     pwdata          = '0;
  logic [HALF_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  in_action       = 1'b0;
  logic [HALF_W-1:0]     in_block_low    = '0;
  logic [HALF_W-1:0]     in_block_high   = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic [HALF_W-1:0]     out_digest_low;
  logic [HALF_W-1:0]     out_digest_high;

  int error_count;
  int digests_owed;
  int sink_hold = 0;
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  ghash_multiply_accumulate DUT (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_action, .in_block_low, .in_block_high,
    .out_valid, .out_ready, .out_digest_low, .out_digest_high
  );

  ghash_digest_checker checker_i (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .in_action, .in_block_low, .in_block_high,
    .out_valid, .out_ready, .out_digest_low, .out_digest_high,
    .error_count, .digests_owed
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // end the run if it hangs
  initial begin
    #6_000_000;
    $display("ghash_multiply_accumulate: mismatch");
    $finish;
  end

  // digest side: random stalls, mostly short, a few long
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_calm) begin
      out_ready <= 1'b1;
    end else if (r < 70) begin
      out_ready <= 1'b1;
    end else if (r < 95) begin
      sink_hold <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      sink_hold <= $urandom_range(8, 40);
      out_ready <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_calm || r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random half-block, with the all-zero and all-one patterns now and then
  function automatic logic [HALF_W-1:0] pick_half();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // present one block and hold it until the transaction completes
  task automatic send_block(input ghash_action_t act, input logic [HALF_W-1:0] blk_low,
                            input logic [HALF_W-1:0] blk_high);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_block_low  <= blk_low;
    in_block_high <= blk_high;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every owed digest has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (digests_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [HALF_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic load_key(input logic [HALF_W-1:0] k_low, input logic [HALF_W-1:0] k_high);
    drain();
    write_reg(REG_KEY_LOW, k_low);
    write_reg(REG_KEY_HIGH, k_high);
  endtask

  // a run of random messages under one key; restarts open new messages
  task automatic random_phase(input int n, input logic [HALF_W-1:0] k_low,
                              input logic [HALF_W-1:0] k_high);
    load_key(k_low, k_high);
    src_calm  = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      send_block(($urandom_range(0, 9) == 0) ? RESTART : ABSORB, pick_half(), pick_half());
      // let the pipeline empty now and then
      if ($urandom_range(0, 79) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero key after reset: every digest is zero
    send_block(ABSORB, ALL_ONES, ALL_ONES);
    send_block(RESTART, {$urandom, $urandom}, {$urandom, $urandom});
    send_block(ABSORB, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    // all-ones key with field extremes
    load_key(ALL_ONES, ALL_ONES);
    send_block(RESTART, '0, '0);
    send_block(ABSORB, ALL_ONES, ALL_ONES);
    send_block(ABSORB, ALL_ONES, ALL_ONES);
    send_block(RESTART, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_block(ABSORB, 64'h1, '0);
    send_block(ABSORB, '0, 64'h8000_0000_0000_0000);

    // key equal to one in the field: digest tracks the running sum
    load_key(64'h80, '0);
    send_block(RESTART, {$urandom, $urandom}, {$urandom, $urandom});
    send_block(ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
    send_block(ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
    send_block(RESTART, ALL_ONES, ALL_ONES);

    // single top key bit
    load_key('0, 64'h8000_0000_0000_0000);
    send_block(RESTART, ALL_ONES, ALL_ONES);
    send_block(ABSORB, ALL_ONES, ALL_ONES);
    send_block(ABSORB, 64'h1, '0);

    // back-to-back blocks with no idling on either side
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_block((i == 3) ? RESTART : ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
    end

    // random part under several keys, extremes included
    random_phase(12, '0, '0);
    random_phase(118, ALL_ONES, ALL_ONES);
    random_phase(118, ALL_ONES, {$urandom, $urandom});
    for (int p = 0; p < 5; p++) begin
      random_phase(118, {$urandom, $urandom}, {$urandom, $urandom});
    end

    drain();
    repeat (12) @(posedge clk);
    if (error_count == 0 && digests_owed == 0) begin
      $display("ghash_multiply_accumulate: match");
    end else begin
      $display("ghash_multiply_accumulate: mismatch");
    end
    $finish;
  end

endmodule
